FILE: rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

  localparam int DATA_W = 32;  // width of one list word
  localparam int POS_W  = 6;   // width of the request position field
  localparam int CNT_W  = 7;   // width of the length and capacity values

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_GET    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } pal_mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } pal_status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;   // insert: the cell at the target loads the word
    logic              del;   // delete: cells at or past the target pull from the right
    logic [DATA_W-1:0] word;  // word to insert
  } pal_cmd_t;

endpackage : pal_pkg

`default_nettype wire

FILE: rtl/core/pal_cell.sv
// One storage cell of the list chain, holding the word at a fixed list position.
`default_nettype none

module pal_cell
  import pal_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire pal_cmd_t          cmd_i,
  input  wire logic [IDX_W-1:0]  pos_i,    // target position of the current request
  input  wire logic [DATA_W-1:0] left_i,   // word held by the cell one position lower
  input  wire logic [DATA_W-1:0] right_i,  // word held by the cell one position higher
  output logic      [DATA_W-1:0] value_o,
  output logic      [DATA_W-1:0] hit_o     // own word when addressed, else zero
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  logic              at_pos;
  logic              past_pos;

  assign at_pos   = (pos_i == MY_IDX);
  assign past_pos = (MY_IDX > pos_i);

  always_comb begin
    value_nxt = value_r;
    if (cmd_i.ins) begin
      if (at_pos) begin
        value_nxt = cmd_i.word;
      end else if (past_pos) begin
        value_nxt = left_i;
      end
    end else if (cmd_i.del && (at_pos || past_pos)) begin
      value_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;
  assign hit_o   = value_r & {DATA_W{at_pos}};

endmodule : pal_cell

`default_nettype wire

FILE: rtl/core/positional_array_list.sv
// Top level of the positional array list: request decode, length counter and cell chain.
// The list lives in a chain of DEPTH cells, one word per list position, and every request
// (insert, get, delete, clear) is finished in the cycle in which it is transferred: all
// cells shift in parallel toward or away from the target position, and the addressed word
// is picked out of the chain by an OR of the per-cell hit outputs. A new request can be
// transferred in every cycle, one request per clock unless the output stalls; the result
// appears in the output register on the cycle after the request and the input side stays
// ready while that register is empty or being drained in the same cycle. Words are not
// cleared by reset, since only positions below the current length are ever read; reset
// empties the list and sets the capacity register to 64, and no clearing pass is needed.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Request channel.
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [39:0]      in_tdata,     // position[5:0], item_value[37:6], zero pad
  input  wire logic [1:0]       in_tuser,     // mode[1:0]
  // Result channel.
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [39:0]      out_tdata,    // read_value[31:0], fill_count[38:32], zero pad
  output logic      [1:0]       out_tuser,    // status[1:0]
  // Capacity register.
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // Request fields.
  pal_mode_t         req_mode;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_word;
  logic              req_xfer;

  assign req_mode  = pal_mode_t'(in_tuser);
  assign req_pos   = in_tdata[POS_W-1:0];
  assign req_word  = in_tdata[POS_W +: DATA_W];

  // State.
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  pal_status_t       out_status_r;
  pal_status_t       out_status_nxt;
  logic [DATA_W-1:0] out_read_r;
  logic [DATA_W-1:0] out_read_nxt;
  logic [CNT_W-1:0]  out_fill_r;

  // Decode.
  logic              list_full;
  logic              pos_bad;
  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  tgt;
  logic [PW-1:0]     tgt_wide;
  logic [IDX_W-1:0]  cell_pos;
  pal_cmd_t          cmd;
  logic [DATA_W-1:0] read_word;

  // Cell chain wiring.
  logic [DATA_W-1:0] vals [DEPTH];
  logic [DATA_W-1:0] hits [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign req_xfer  = in_tvalid && in_tready;

  // The list is full at the capacity register or at the store depth, whichever is lower.
  assign list_full = (cnt_r >= cap_r) || (int'(cnt_r) >= DEPTH);
  assign pos_ext   = CNT_W'(req_pos);
  assign pos_bad   = (pos_ext >= cnt_r);

  // An insert past the end appends at the end.
  always_comb begin
    tgt = pos_ext;
    if ((req_mode == MODE_INSERT) && (pos_ext > cnt_r)) begin
      tgt = cnt_r;
    end
  end

  assign tgt_wide = PW'(tgt);
  assign cell_pos = tgt_wide[IDX_W-1:0];

  assign cmd.ins  = req_xfer && (req_mode == MODE_INSERT) && !list_full;
  assign cmd.del  = req_xfer && (req_mode == MODE_DELETE) && !pos_bad;
  assign cmd.word = req_word;

  // Pick the addressed word out of the chain.
  always_comb begin
    read_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_word = read_word | hits[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = req_word;
    end else begin : g_mid_l
      assign left_w = vals[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = vals[g];
    end else begin : g_mid_r
      assign right_w = vals[g+1];
    end

    pal_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .pos_i   (cell_pos),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (vals[g]),
      .hit_o   (hits[g])
    );
  end

  // Result and next length.
  always_comb begin
    cnt_nxt        = cnt_r;
    out_status_nxt = ST_OK;
    out_read_nxt   = '0;
    case (req_mode)
      MODE_INSERT: begin
        if (list_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      MODE_GET: begin
        if (pos_bad) begin
          out_status_nxt = ST_BADPOS;
        end else begin
          out_read_nxt = read_word;
        end
      end
      MODE_DELETE: begin
        if (pos_bad) begin
          out_status_nxt = ST_BADPOS;
        end else begin
          out_read_nxt = read_word;
          cnt_nxt      = cnt_r - CNT_W'(1);
        end
      end
      MODE_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (req_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (req_xfer) begin
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      out_status_r <= out_status_nxt;
      out_read_r   <= out_read_nxt;
      out_fill_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_fill_r, out_read_r};

  // The length never goes past the store depth.
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= DEPTH)
    else $error("list length beyond store depth");

  // A successful insert grows the list by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (req_xfer && (req_mode == MODE_INSERT) && !list_full) |=>
      (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  // A refused insert leaves the length alone and reports a full list.
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (req_xfer && (req_mode == MODE_INSERT) && list_full) |=>
      ((cnt_r == $past(cnt_r)) && (out_status_r == ST_FULL)))
    else $error("refused insert changed the list");

  // A clear empties the list and reports an empty list.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (req_xfer && (req_mode == MODE_CLEAR)) |=> ((cnt_r == '0) && (out_fill_r == '0)))
    else $error("clear left entries in the list");

  // Every transferred request leaves a result waiting in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req_xfer |=> out_valid_r)
    else $error("request transfer produced no result");

endmodule : positional_array_list

`default_nettype wire

FILE: sim/tb_positional_array_list.sv
// Self-checking testbench for the positional array list: stream stimulus, predictor, checks.
`timescale 1ns / 100ps

module tb_positional_array_list
  import pal_pkg::*;
();

  // The store depth of the block under test.
  localparam int LIST_DEPTH = 64;
  // Give up after this many clock cycles. The slowest legal run stays far below it.
  localparam int CYCLE_LIMIT = 1000000;
  // Number of random requests in each capacity phase.
  localparam int PHASE_ITEMS = 140;

  // One request as it goes onto the input stream.
  typedef struct {
    pal_mode_t         mode;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;
  } request_t;

  // One result as the block should return it.
  typedef struct {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  fill_count;
  } list_result_t;

  // Mix of operations used by one random phase.
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } op_mix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;     // position[5:0], item_value[37:6], zero pad
  logic [1:0]        in_tuser = '0;     // mode[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;         // read_value[31:0], fill_count[38:32], zero pad
  logic [1:0]        out_tuser;         // status[1:0]
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;

  // Requests waiting for the driver, and results waiting for the block.
  request_t     pending_reqs[$];
  list_result_t expected_results[$];

  // Predictor state: the list words, its length and the capacity register.
  logic [DATA_W-1:0] list_words [0:LIST_DEPTH-1];
  int                list_len;
  logic [CNT_W-1:0]  list_cap;

  // Length and capacity as the stimulus generator expects them to be once the
  // queued requests have run. Only used to aim positions at live entries.
  int                plan_len = 0;
  int                plan_cap = CAP_RESET;

  // Driver and monitor bookkeeping.
  logic              took_item = 1'b0;
  int                in_gap = 0;
  int                in_calm = 0;
  int                out_stall = 0;
  int                out_calm = 0;
  request_t          drive_req;
  list_result_t      due_result;
  int                fail_count = 0;
  int                cycle_count = 0;

  positional_array_list #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length for either side of the stream: mostly none or short, now and
  // then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the predicted list and returns the result it yields.
  // A capacity above the store depth acts as the depth; inserts past the end
  // append; get and delete beyond the length leave the list untouched.
  function automatic list_result_t apply_request(pal_mode_t mode, logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] word);
    list_result_t res;
    int           room;
    int           slot;
    int           i;
    res.status     = ST_OK;
    res.read_value = '0;
    room = (list_cap > LIST_DEPTH) ? LIST_DEPTH : int'(list_cap);
    slot = int'(pos);
    case (mode)
      MODE_INSERT: begin
        if (list_len >= room) begin
          res.status = ST_FULL;
        end else begin
          if (slot > list_len) slot = list_len;
          for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = word;
          list_len++;
        end
      end
      MODE_GET: begin
        if (slot >= list_len) res.status = ST_BADPOS;
        else res.read_value = list_words[slot];
      end
      MODE_DELETE: begin
        if (slot >= list_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.read_value = list_words[slot];
          for (i = slot + 1; i < list_len; i++) list_words[i-1] = list_words[i];
          list_len--;
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    res.fill_count = list_len[CNT_W-1:0];
    return res;
  endfunction

  // Watches the request side: every transfer is run through the predictor, and
  // capacity writes reach the predictor at the same edge as the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      list_cap = CAP_RESET;
      took_item <= 1'b0;
    end else begin
      if (cfg_wr_en) list_cap = cfg_wr_data;
      took_item <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(pal_mode_t'(in_tuser), in_tdata[POS_W-1:0],
                                                 in_tdata[POS_W +: DATA_W]));
      end
    end
  end

  // Request driver. A request is held until its transfer; after that comes a
  // random gap, except during calm stretches where requests go back to back.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || took_item) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drive_req = pending_reqs.pop_front();
        in_tdata  <= {2'b00, drive_req.word, drive_req.pos};
        in_tuser  <= drive_req.mode;
        in_tvalid <= 1'b1;
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else begin
          in_gap = pick_gap();
          if ($urandom_range(0, 99) < 3) in_calm = $urandom_range(20, 80);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure: random stalls with calm stretches in between.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_calm > 0) begin
        out_calm--;
      end else begin
        out_stall = pick_gap();
        if ($urandom_range(0, 99) < 3) out_calm = $urandom_range(20, 80);
      end
    end
  end

  // Result monitor: every result transfer is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d, read_value %h, fill_count %0d",
               out_tuser, out_tdata[DATA_W-1:0], out_tdata[DATA_W +: CNT_W]);
        fail_count++;
      end else begin
        due_result = expected_results.pop_front();
        if (out_tuser !== due_result.status) begin
          $error("status mismatch: expected %0d, got %0d", due_result.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[DATA_W-1:0] !== due_result.read_value) begin
          $error("read_value mismatch: expected %h, got %h", due_result.read_value,
                 out_tdata[DATA_W-1:0]);
          fail_count++;
        end
        if (out_tdata[DATA_W +: CNT_W] !== due_result.fill_count) begin
          $error("fill_count mismatch: expected %0d, got %0d", due_result.fill_count,
                 out_tdata[DATA_W +: CNT_W]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog for a block that stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Queues one request and keeps the planned length in step with it.
  task automatic queue_request(input pal_mode_t mode, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] word);
    request_t req;
    int       room;
    room = (plan_cap > LIST_DEPTH) ? LIST_DEPTH : plan_cap;
    case (mode)
      MODE_INSERT: if (plan_len < room) plan_len++;
      MODE_DELETE: if (int'(pos) < plan_len) plan_len--;
      MODE_CLEAR:  plan_len = 0;
      default: ;
    endcase
    req.mode = mode;
    req.pos  = pos;
    req.word = word;
    pending_reqs.push_back(req);
  endtask

  // Waits until every queued request has been transferred and answered.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes the capacity register while the block is idle.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    plan_cap = int'(value);
  endtask

  // Queues a run of random requests. Positions mostly land on live entries so
  // that gets and deletes do real work; the rest roam the whole field.
  task automatic queue_random_phase(input op_mix_t mix, input int count);
    int                n;
    int                roll;
    int                ins_edge;
    int                get_edge;
    int                del_edge;
    pal_mode_t         mode;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;
    case (mix)
      MIX_GROW:   begin ins_edge = 60; get_edge = 80; del_edge = 99; end
      MIX_SHRINK: begin ins_edge = 20; get_edge = 45; del_edge = 98; end
      default:    begin ins_edge = 40; get_edge = 65; del_edge = 97; end
    endcase
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_edge) mode = MODE_INSERT;
      else if (roll < get_edge) mode = MODE_GET;
      else if (roll < del_edge) mode = MODE_DELETE;
      else mode = MODE_CLEAR;

      roll = $urandom_range(0, 99);
      if (mode == MODE_INSERT && roll < 70)
        pos = POS_W'($urandom_range(0, (plan_len > 63) ? 63 : plan_len));
      else if (mode != MODE_INSERT && plan_len > 0 && roll < 80)
        pos = POS_W'($urandom_range(0, plan_len - 1));
      else
        pos = POS_W'($urandom_range(0, 63));

      roll = $urandom_range(0, 99);
      if (roll < 5) word = '0;
      else if (roll < 10) word = '1;
      else word = $urandom;

      queue_request(mode, pos, word);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset capacity: requests on an empty list,
    // insert at the front, in the middle and past the end, reads of every
    // entry and just beyond, deletes of middle, tail and head, and a clear
    // that carries a position and a word it must ignore.
    queue_request(MODE_GET,    6'd0,  32'h0000_0000);
    queue_request(MODE_DELETE, 6'd0,  32'hFFFF_FFFF);
    queue_request(MODE_CLEAR,  6'd0,  32'h0000_0000);
    queue_request(MODE_INSERT, 6'd0,  32'h0000_0000);
    queue_request(MODE_INSERT, 6'd63, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 6'd0,  32'hA5A5_A5A5);
    queue_request(MODE_INSERT, 6'd1,  32'h5A5A_5A5A);
    queue_request(MODE_GET,    6'd0,  32'h0000_0000);
    queue_request(MODE_GET,    6'd1,  32'h0000_0000);
    queue_request(MODE_GET,    6'd2,  32'hFFFF_FFFF);
    queue_request(MODE_GET,    6'd3,  32'h0000_0000);
    queue_request(MODE_GET,    6'd4,  32'h0000_0000);
    queue_request(MODE_GET,    6'd63, 32'h0000_0000);
    queue_request(MODE_DELETE, 6'd63, 32'h0000_0000);
    queue_request(MODE_DELETE, 6'd1,  32'h0000_0000);
    queue_request(MODE_DELETE, 6'd2,  32'h0000_0000);
    queue_request(MODE_DELETE, 6'd0,  32'h0000_0000);
    queue_request(MODE_GET,    6'd0,  32'h0000_0000);
    queue_request(MODE_INSERT, 6'd5,  32'h1234_5678);
    queue_request(MODE_CLEAR,  6'd63, 32'hDEAD_BEEF);
    queue_request(MODE_GET,    6'd0,  32'h0000_0000);
    queue_request(MODE_INSERT, 6'd0,  32'h8000_0001);
    queue_request(MODE_GET,    6'd0,  32'hFFFF_FFFF);

    // Random phases over a spread of capacities. The list is not cleared
    // between phases, so a smaller capacity often finds the list longer than
    // itself and inserts must fail until deletes bring it down. Capacities
    // above the store depth and a capacity of zero are covered as well.
    queue_random_phase(MIX_GROW, PHASE_ITEMS);
    write_capacity(7'd127);
    queue_random_phase(MIX_GROW, PHASE_ITEMS);
    write_capacity(7'd2);
    queue_random_phase(MIX_CHURN, PHASE_ITEMS);
    write_capacity(7'd0);
    queue_random_phase(MIX_CHURN, PHASE_ITEMS);
    write_capacity(7'd1);
    queue_random_phase(MIX_CHURN, PHASE_ITEMS);
    write_capacity(7'd64);
    queue_random_phase(MIX_GROW, PHASE_ITEMS);
    write_capacity(7'd100);
    queue_random_phase(MIX_SHRINK, PHASE_ITEMS);
    write_capacity(7'd33);
    queue_random_phase(MIX_GROW, PHASE_ITEMS);
    write_capacity(7'd65);
    queue_random_phase(MIX_GROW, PHASE_ITEMS);
    write_capacity(7'd17);
    queue_random_phase(MIX_SHRINK, PHASE_ITEMS);
    write_capacity(7'd64);
    queue_random_phase(MIX_CHURN, PHASE_ITEMS);
    write_capacity(7'd127);
    queue_random_phase(MIX_CHURN, PHASE_ITEMS);

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
